// ===== hdl/arpc_pkg.sv =====
// shared types, codes and defaults for the arp cache with request retry
// no dependencies
package arpc_pkg;

    // default sizes
    localparam int CacheEntries      = 16;
    localparam int RequestEntries    = 8;
    localparam int PacketsPerRequest = 4;
    localparam int ResultLimit       = 32;
    localparam int ResCntW           = $clog2(ResultLimit + 1);

    // operation codes
    localparam logic [2:0] OpTick   = 3'd0;
    localparam logic [2:0] OpLookup = 3'd1;
    localparam logic [2:0] OpQueue  = 3'd2;
    localparam logic [2:0] OpInsert = 3'd3;
    localparam logic [2:0] OpRemove = 3'd4;
    localparam logic [2:0] OpClear  = 3'd5;

    // result kinds
    localparam logic [2:0] KindLookup  = 3'd0;
    localparam logic [2:0] KindSend    = 3'd1;
    localparam logic [2:0] KindUnreach = 3'd2;
    localparam logic [2:0] KindInsert  = 3'd3;
    localparam logic [2:0] KindQueue   = 3'd4;
    localparam logic [2:0] KindDone    = 3'd5;

    // status codes
    localparam logic [1:0] StatusOk        = 2'd0;
    localparam logic [1:0] StatusCacheFull = 2'd1;
    localparam logic [1:0] StatusReqFull   = 2'd2;
    localparam logic [1:0] StatusPktFull   = 2'd3;

    // configuration register indexes and reset values
    localparam logic [1:0] CfgTimeout  = 2'd0;
    localparam logic [1:0] CfgInterval = 2'd1;
    localparam logic [1:0] CfgMaxSends = 2'd2;
    localparam logic [15:0] TimeoutReset  = 16'd30;
    localparam logic [7:0]  IntervalReset = 8'd1;
    localparam logic [2:0]  MaxSendsReset = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] age;
    } cache_ent_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [2:0]  sends;
        logic [7:0]  wait_cnt;
    } req_ent_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [3:0]  iface;
    } held_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] handle;
        logic [3:0]  iface;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== hdl/arpc_cache_cell.sv =====
// one cache entry cell of the rotating cache ring
// depends on arpc_pkg
module arpc_cache_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                clear,
    input  arpc_pkg::cache_ent_t d_in,
    output arpc_pkg::cache_ent_t q
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [15:0] age_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d_in.valid;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ip_reg  <= d_in.ip;
            mac_reg <= d_in.mac;
            age_reg <= d_in.age;
        end
    end

    assign q = '{valid: valid_reg, ip: ip_reg, mac: mac_reg, age: age_reg};

endmodule

// ===== hdl/arpc_req_cell.sv =====
// one pending request cell of the rotating request ring, with its held packets
// depends on arpc_pkg
module arpc_req_cell #(
    parameter int P    = arpc_pkg::PacketsPerRequest,
    parameter int CntW = $clog2(P + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              clear,
    input  arpc_pkg::req_ent_t ent_in,
    input  logic [CntW-1:0]   cnt_in,
    input  arpc_pkg::held_t   pkt_in [P],
    output arpc_pkg::req_ent_t ent_q,
    output logic [CntW-1:0]   cnt_q,
    output arpc_pkg::held_t   pkt_q [P]
);

    logic               valid_reg;
    logic [31:0]        ip_reg;
    logic [2:0]         sends_reg;
    logic [7:0]         wait_reg;
    logic [CntW-1:0]    cnt_reg;
    arpc_pkg::held_t    pkt_reg [P];

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= ent_in.valid;
        end
    end

    // request payload and held packets
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ip_reg    <= ent_in.ip;
            sends_reg <= ent_in.sends;
            wait_reg  <= ent_in.wait_cnt;
            cnt_reg   <= cnt_in;
            for (int j = 0; j < P; j++)
            begin
                pkt_reg[j] <= pkt_in[j];
            end
        end
    end

    assign ent_q = '{valid: valid_reg, ip: ip_reg, sends: sends_reg, wait_cnt: wait_reg};
    assign cnt_q = cnt_reg;
    assign pkt_q = pkt_reg;

endmodule

// ===== hdl/arp_cache_with_request_retry.sv =====
// top level: arp cache and pending request table as two rotating rings of cells
// depends on arpc_pkg, arpc_cache_cell, arpc_req_cell
//
// One word is taken at a time and its results come out at most one word per cycle,
// the final one marked by last. Both tables are rings of cells that rotate by one
// each cycle of a pass (the request ring waits while a result cannot move out)
// past a single head unit, so an operation costs whole ring passes: a lookup one
// cache pass, an insert two cache passes and a request pass, a queue two request
// passes, a remove one request pass, a clear none, and a tick one cache pass and
// one request pass plus, for each request given up, one unreachable word per held
// packet; all of these run longer while the output is stalled.
module arp_cache_with_request_retry #(
    parameter int CACHE_ENTRIES       = arpc_pkg::CacheEntries,
    parameter int REQUEST_ENTRIES     = arpc_pkg::RequestEntries,
    parameter int PACKETS_PER_REQUEST = arpc_pkg::PacketsPerRequest
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] ip,
    input  logic [47:0] mac,
    input  logic [15:0] packet_handle,
    input  logic [3:0]  iface,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic        hit,
    output logic [47:0] mac_res,
    output logic [31:0] ip_res,
    output logic [15:0] packet_handle_res,
    output logic [3:0]  iface_res,
    output logic [1:0]  status,
    output logic        last
);

    localparam int CIdxW = $clog2(CACHE_ENTRIES);
    localparam int RIdxW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int CntW  = $clog2(PACKETS_PER_REQUEST + 1);
    localparam int PIdxW = (PACKETS_PER_REQUEST > 1) ? $clog2(PACKETS_PER_REQUEST) : 1;
    localparam logic [CIdxW-1:0] CLast = CIdxW'(CACHE_ENTRIES - 1);
    localparam logic [RIdxW-1:0] RLast = RIdxW'(REQUEST_ENTRIES - 1);
    localparam logic [CntW-1:0]  PFull = CntW'(PACKETS_PER_REQUEST);

    typedef enum logic [2:0] {
        S_IDLE, S_CPASS1, S_CPASS2, S_RPASS1, S_RGIVEUP, S_RPASS2, S_FINISH
    } state_t;

    // rings
    arpc_pkg::cache_ent_t c_q [CACHE_ENTRIES];
    arpc_pkg::cache_ent_t c_d [CACHE_ENTRIES];
    arpc_pkg::req_ent_t   r_q [REQUEST_ENTRIES];
    arpc_pkg::req_ent_t   r_d [REQUEST_ENTRIES];
    logic [CntW-1:0]      r_cq [REQUEST_ENTRIES];
    logic [CntW-1:0]      r_cd [REQUEST_ENTRIES];
    arpc_pkg::held_t      r_pq [REQUEST_ENTRIES][PACKETS_PER_REQUEST];
    arpc_pkg::held_t      r_pd [REQUEST_ENTRIES][PACKETS_PER_REQUEST];

    arpc_pkg::cache_ent_t c_head_next;
    arpc_pkg::req_ent_t   r_head_next;
    logic [CntW-1:0]      r_cnt_head_next;
    arpc_pkg::held_t      r_pkt_head_next [PACKETS_PER_REQUEST];
    logic                 c_shift, r_shift, clear;

    // control and working registers
    state_t                        state_reg, state_next;
    logic [2:0]                    op_reg, op_next;
    logic [31:0]                   ip_reg, ip_next;
    logic [47:0]                   mac_reg, mac_next;
    arpc_pkg::held_t               pkt_reg, pkt_next;
    logic [CIdxW-1:0]              c_idx_reg, c_idx_next;
    logic [RIdxW-1:0]              r_idx_reg, r_idx_next;
    logic [CntW-1:0]               k_reg, k_next;
    logic                          found_reg, found_next;
    logic                          free_reg, free_next;
    logic [CIdxW-1:0]              sel_c_reg, sel_c_next, free_c_reg, free_c_next;
    logic [RIdxW-1:0]              sel_r_reg, sel_r_next, free_r_reg, free_r_next;
    logic [47:0]                   mac_hit_reg, mac_hit_next;
    logic [1:0]                    status_reg, status_next;
    arpc_pkg::result_t             hold_reg, hold_next;
    logic                          hold_valid_reg, hold_valid_next;
    arpc_pkg::result_t             out_reg, out_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_valid_reg, out_valid_next;
    logic [arpc_pkg::ResCntW-1:0]  res_cnt_reg, res_cnt_next;
    logic [15:0]                   timeout_reg;
    logic [7:0]                    interval_reg;
    logic [2:0]                    max_sends_reg;

    // cache ring
    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cache
        if (i == CACHE_ENTRIES - 1)
        begin : g_tail
            assign c_d[i] = c_head_next;
        end
        else
        begin : g_mid
            assign c_d[i] = c_q[i+1];
        end
        arpc_cache_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (c_shift),
            .clear (clear),
            .d_in  (c_d[i]),
            .q     (c_q[i])
        );
    end

    // request ring
    for (genvar i = 0; i < REQUEST_ENTRIES; i++)
    begin : g_req
        if (i == REQUEST_ENTRIES - 1)
        begin : g_tail
            assign r_d[i]  = r_head_next;
            assign r_cd[i] = r_cnt_head_next;
            assign r_pd[i] = r_pkt_head_next;
        end
        else
        begin : g_mid
            assign r_d[i]  = r_q[i+1];
            assign r_cd[i] = r_cq[i+1];
            assign r_pd[i] = r_pq[i+1];
        end
        arpc_req_cell #(
            .P    (PACKETS_PER_REQUEST),
            .CntW (CntW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .shift  (r_shift),
            .clear  (clear),
            .ent_in (r_d[i]),
            .cnt_in (r_cd[i]),
            .pkt_in (r_pd[i]),
            .ent_q  (r_q[i]),
            .cnt_q  (r_cq[i]),
            .pkt_q  (r_pq[i])
        );
    end

    // sequencer and head logic
    always_comb
    begin
        logic              accept, out_free, emit_req, emit_ok, c_match, r_match;
        logic              due, c_end;
        logic [15:0]       age_inc;
        logic [7:0]        wait_inc;
        arpc_pkg::result_t emit_word;

        state_next      = state_reg;
        op_next         = op_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        pkt_next        = pkt_reg;
        c_idx_next      = c_idx_reg;
        r_idx_next      = r_idx_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        free_next       = free_reg;
        sel_c_next      = sel_c_reg;
        free_c_next     = free_c_reg;
        sel_r_next      = sel_r_reg;
        free_r_next     = free_r_reg;
        mac_hit_next    = mac_hit_reg;
        status_next     = status_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        res_cnt_next    = res_cnt_reg;
        c_shift         = 1'b0;
        r_shift         = 1'b0;
        clear           = 1'b0;
        c_head_next     = c_q[0];
        r_head_next     = r_q[0];
        r_cnt_head_next = r_cq[0];
        r_pkt_head_next = r_pq[0];
        emit_req        = 1'b0;
        emit_ok         = 1'b0;
        c_end           = 1'b0;
        emit_word       = '0;

        accept   = in_valid && (state_reg == S_IDLE);
        out_free = !out_valid_reg || !out_stall;
        c_match  = c_q[0].valid && (c_q[0].ip == ip_reg);
        r_match  = r_q[0].valid && (r_q[0].ip == ip_reg);
        age_inc  = (c_q[0].age != 16'hFFFF) ? c_q[0].age + 16'd1 : c_q[0].age;
        wait_inc = (r_q[0].wait_cnt != 8'hFF) ? r_q[0].wait_cnt + 8'd1 : r_q[0].wait_cnt;
        due      = (r_q[0].sends == 3'd0) || (wait_inc > interval_reg);

        // output register drains
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next           = op;
                    ip_next           = ip;
                    mac_next          = mac;
                    pkt_next.handle   = packet_handle;
                    pkt_next.iface    = iface;
                    c_idx_next        = '0;
                    r_idx_next        = '0;
                    found_next        = 1'b0;
                    free_next         = 1'b0;
                    status_next       = arpc_pkg::StatusOk;
                    res_cnt_next      = '0;
                    hold_valid_next   = 1'b0;
                    case (op)
                        arpc_pkg::OpTick:   state_next = S_CPASS1;
                        arpc_pkg::OpLookup: state_next = S_CPASS1;
                        arpc_pkg::OpInsert: state_next = S_CPASS1;
                        arpc_pkg::OpQueue:  state_next = S_RPASS1;
                        arpc_pkg::OpRemove: state_next = S_RPASS1;
                        arpc_pkg::OpClear:
                        begin
                            clear      = 1'b1;
                            state_next = S_FINISH;
                        end
                        default:            state_next = S_FINISH;
                    endcase
                end
            end

            S_CPASS1:
            begin
                c_shift    = 1'b1;
                c_end      = (c_idx_reg == CLast);
                c_idx_next = c_idx_reg + 1'b1;
                if (op_reg == arpc_pkg::OpTick)
                begin
                    // age and expire
                    if (c_q[0].valid)
                    begin
                        c_head_next.age = age_inc;
                        if (age_inc >= timeout_reg)
                        begin
                            c_head_next.valid = 1'b0;
                        end
                    end
                end
                else
                begin
                    // first match and first free slot
                    if (c_match && !found_reg)
                    begin
                        found_next   = 1'b1;
                        sel_c_next   = c_idx_reg;
                        mac_hit_next = c_q[0].mac;
                    end
                    if (!c_q[0].valid && !free_reg)
                    begin
                        free_next   = 1'b1;
                        free_c_next = c_idx_reg;
                    end
                end
                if (c_end)
                begin
                    c_idx_next = '0;
                    case (op_reg)
                        arpc_pkg::OpTick:
                        begin
                            state_next = S_RPASS1;
                        end
                        arpc_pkg::OpLookup:
                        begin
                            hold_next        = '0;
                            hold_next.kind   = arpc_pkg::KindLookup;
                            hold_next.hit    = found_next;
                            hold_next.mac    = found_next ? mac_hit_next : 48'd0;
                            hold_valid_next  = 1'b1;
                            res_cnt_next     = res_cnt_reg + 1'b1;
                            state_next       = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_CPASS2;
                        end
                    endcase
                end
            end

            S_CPASS2:
            begin
                c_shift    = 1'b1;
                c_idx_next = c_idx_reg + 1'b1;
                // write the chosen slot
                if ((found_reg && (c_idx_reg == sel_c_reg)) ||
                    (!found_reg && free_reg && (c_idx_reg == free_c_reg)))
                begin
                    c_head_next.valid = 1'b1;
                    c_head_next.ip    = ip_reg;
                    c_head_next.mac   = mac_reg;
                    c_head_next.age   = 16'd0;
                end
                if (c_idx_reg == CLast)
                begin
                    c_idx_next  = '0;
                    status_next = (found_reg || free_reg) ? arpc_pkg::StatusOk
                                                          : arpc_pkg::StatusCacheFull;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    r_idx_next  = '0;
                    state_next  = S_RPASS1;
                end
            end

            S_RPASS1:
            begin
                if (op_reg == arpc_pkg::OpTick)
                begin
                    if (!r_q[0].valid)
                    begin
                        r_shift = 1'b1;
                    end
                    else if (!due)
                    begin
                        r_shift              = 1'b1;
                        r_head_next.wait_cnt = wait_inc;
                    end
                    else if (r_q[0].sends >= max_sends_reg)
                    begin
                        k_next     = '0;
                        state_next = S_RGIVEUP;
                    end
                    else
                    begin
                        // resend
                        emit_req       = 1'b1;
                        emit_word.kind = arpc_pkg::KindSend;
                        emit_word.ip   = r_q[0].ip;
                        emit_ok        = (res_cnt_reg >= arpc_pkg::ResCntW'(arpc_pkg::ResultLimit))
                                         || !hold_valid_reg || out_free;
                        if (emit_ok)
                        begin
                            r_shift              = 1'b1;
                            r_head_next.wait_cnt = 8'd0;
                            r_head_next.sends    = r_q[0].sends + 3'd1;
                        end
                    end
                    if (r_shift)
                    begin
                        r_idx_next = r_idx_reg + 1'b1;
                        if (r_idx_reg == RLast)
                        begin
                            r_idx_next = '0;
                            state_next = S_FINISH;
                        end
                    end
                end
                else
                begin
                    r_shift    = 1'b1;
                    r_idx_next = r_idx_reg + 1'b1;
                    if (r_match && !found_reg)
                    begin
                        found_next = 1'b1;
                        sel_r_next = r_idx_reg;
                        if (op_reg == arpc_pkg::OpRemove)
                        begin
                            r_head_next.valid = 1'b0;
                        end
                    end
                    if (!r_q[0].valid && !free_reg)
                    begin
                        free_next   = 1'b1;
                        free_r_next = r_idx_reg;
                    end
                    if (r_idx_reg == RLast)
                    begin
                        r_idx_next = '0;
                        case (op_reg)
                            arpc_pkg::OpQueue:
                            begin
                                state_next = S_RPASS2;
                            end
                            arpc_pkg::OpInsert:
                            begin
                                hold_next        = '0;
                                hold_next.kind   = arpc_pkg::KindInsert;
                                hold_next.hit    = found_next;
                                hold_next.ip     = ip_reg;
                                hold_next.status = status_reg;
                                hold_valid_next  = 1'b1;
                                res_cnt_next     = res_cnt_reg + 1'b1;
                                state_next       = S_FINISH;
                            end
                            default:
                            begin
                                state_next = S_FINISH;
                            end
                        endcase
                    end
                end
            end

            S_RGIVEUP:
            begin
                if (k_reg < r_cq[0])
                begin
                    // one unreachable word per held packet
                    emit_req         = 1'b1;
                    emit_word.kind   = arpc_pkg::KindUnreach;
                    emit_word.ip     = r_q[0].ip;
                    emit_word.handle = r_pq[0][k_reg[PIdxW-1:0]].handle;
                    emit_word.iface  = r_pq[0][k_reg[PIdxW-1:0]].iface;
                    emit_ok          = (res_cnt_reg >= arpc_pkg::ResCntW'(arpc_pkg::ResultLimit))
                                       || !hold_valid_reg || out_free;
                    if (emit_ok)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    r_shift           = 1'b1;
                    r_head_next.valid = 1'b0;
                    r_idx_next        = r_idx_reg + 1'b1;
                    state_next        = S_RPASS1;
                    if (r_idx_reg == RLast)
                    begin
                        r_idx_next = '0;
                        state_next = S_FINISH;
                    end
                end
            end

            S_RPASS2:
            begin
                r_shift    = 1'b1;
                r_idx_next = r_idx_reg + 1'b1;
                if (found_reg && (r_idx_reg == sel_r_reg))
                begin
                    // append to existing request
                    if (r_cq[0] < PFull)
                    begin
                        for (int j = 0; j < PACKETS_PER_REQUEST; j++)
                        begin
                            if (PIdxW'(j) == r_cq[0][PIdxW-1:0])
                            begin
                                r_pkt_head_next[j] = pkt_reg;
                            end
                        end
                        r_cnt_head_next = r_cq[0] + 1'b1;
                    end
                    else
                    begin
                        status_next = arpc_pkg::StatusPktFull;
                    end
                end
                else if (!found_reg && free_reg && (r_idx_reg == free_r_reg))
                begin
                    // allocate a new request
                    r_head_next.valid    = 1'b1;
                    r_head_next.ip       = ip_reg;
                    r_head_next.sends    = 3'd0;
                    r_head_next.wait_cnt = 8'd0;
                    r_pkt_head_next[0]   = pkt_reg;
                    r_cnt_head_next      = CntW'(1);
                end
                if (r_idx_reg == RLast)
                begin
                    r_idx_next = '0;
                    if (!found_reg && !free_reg)
                    begin
                        status_next = arpc_pkg::StatusReqFull;
                    end
                    hold_next        = '0;
                    hold_next.kind   = arpc_pkg::KindQueue;
                    hold_next.ip     = ip_reg;
                    hold_next.status = status_next;
                    hold_valid_next  = 1'b1;
                    res_cnt_next     = res_cnt_reg + 1'b1;
                    state_next       = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // push the final word with last set
                if (out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next = hold_reg;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_next.kind = arpc_pkg::KindDone;
                    end
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result staging: the held word moves out when a newer one arrives
        if (emit_req && (res_cnt_reg < arpc_pkg::ResCntW'(arpc_pkg::ResultLimit)) &&
            (!hold_valid_reg || out_free))
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_word;
            hold_valid_next = 1'b1;
            res_cnt_next    = res_cnt_reg + 1'b1;
        end
    end

    // state, handshake and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= arpc_pkg::TimeoutReset;
            interval_reg   <= arpc_pkg::IntervalReset;
            max_sends_reg  <= arpc_pkg::MaxSendsReset;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    arpc_pkg::CfgTimeout:  timeout_reg   <= wr_data;
                    arpc_pkg::CfgInterval: interval_reg  <= wr_data[7:0];
                    arpc_pkg::CfgMaxSends: max_sends_reg <= wr_data[2:0];
                    default:               ;
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        pkt_reg      <= pkt_next;
        c_idx_reg    <= c_idx_next;
        r_idx_reg    <= r_idx_next;
        k_reg        <= k_next;
        found_reg    <= found_next;
        free_reg     <= free_next;
        sel_c_reg    <= sel_c_next;
        free_c_reg   <= free_c_next;
        sel_r_reg    <= sel_r_next;
        free_r_reg   <= free_r_next;
        mac_hit_reg  <= mac_hit_next;
        status_reg   <= status_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        res_cnt_reg  <= res_cnt_next;
    end

    // ports
    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign kind              = out_reg.kind;
    assign hit               = out_reg.hit;
    assign mac_res           = out_reg.mac;
    assign ip_res            = out_reg.ip;
    assign packet_handle_res = out_reg.handle;
    assign iface_res         = out_reg.iface;
    assign status            = out_reg.status;
    assign last              = out_last_reg;

endmodule
